// ----- hdl/glpf_pkg.sv -----
// Shared constants and types of the grid local peak finder.
package glpf_pkg;

	localparam int DEF_MAX_COLS    = 32;
	localparam int DEF_MAX_ROWS    = 1024;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int ROWS_CFG_W  = 11;
	localparam int COLS_CFG_W  = 6;
	localparam int CFG_DATA_W  = 11;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = 1'b1;

	localparam int PEAK_ROW_W = 10;
	localparam int PEAK_COL_W = 5;

	localparam int QUEUE_DEPTH = 2;

	// Where an item sits in the frame, worked out when it is accepted.
	typedef struct packed {
		logic last_row;
		logic last_col;
	} glpf_place_t;

	localparam int PLACE_W = $bits(glpf_place_t);

endpackage

// ----- hdl/glpf_front.sv -----
// Front end: configuration registers, raster counters and item classification.
module glpf_front import glpf_pkg::*; #(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          sample_valid,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          queue_full,
	output logic                          push,
	output logic signed [SAMPLE_BITS-1:0] push_sample,
	output logic [$clog2(MAX_ROWS)-1:0]   push_row,
	output logic [$clog2(MAX_COLS)-1:0]   push_col,
	output glpf_place_t                   push_place
);

	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CW  = $clog2(MAX_COLS);
	localparam int REW = (RW + 1 > ROWS_CFG_W) ? RW + 1 : ROWS_CFG_W;
	localparam int CEW = (CW + 1 > COLS_CFG_W) ? CW + 1 : COLS_CFG_W;

	logic [ROWS_CFG_W-1:0] frame_rows_q;
	logic [COLS_CFG_W-1:0] frame_cols_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;
	logic [REW-1:0]        rows_eff;
	logic [CEW-1:0]        cols_eff;
	glpf_place_t           place;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= ROWS_CFG_W'(1);
			frame_cols_q <= COLS_CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data[ROWS_CFG_W-1:0];
				REG_FRAME_COLS: frame_cols_q <= cfg_data[COLS_CFG_W-1:0];
			endcase
		end
	end

	// Zero counts act as one, counts beyond the maximum act as the maximum.
	always_comb begin
		if (frame_rows_q == '0) begin
			rows_eff = REW'(1);
		end else if (REW'(frame_rows_q) > REW'(MAX_ROWS)) begin
			rows_eff = REW'(MAX_ROWS);
		end else begin
			rows_eff = REW'(frame_rows_q);
		end
		if (frame_cols_q == '0) begin
			cols_eff = CEW'(1);
		end else if (CEW'(frame_cols_q) > CEW'(MAX_COLS)) begin
			cols_eff = CEW'(MAX_COLS);
		end else begin
			cols_eff = CEW'(frame_cols_q);
		end
	end

	assign place.last_row = (REW'(row_q) + REW'(1)) >= rows_eff;
	assign place.last_col = (CEW'(col_q) + CEW'(1)) >= cols_eff;

	assign push        = sample_valid && !queue_full;
	assign push_sample = sample;
	assign push_row    = row_q;
	assign push_col    = col_q;
	assign push_place  = place;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (place.last_col) begin
				col_q <= '0;
				row_q <= place.last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- hdl/glpf_queue.sv -----
// Short item queue between the front end and the back end.
module glpf_queue import glpf_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign full     = count_q == NW'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/glpf_back.sv -----
// Back end: line stores, peak decisions, last-row flag flush and result register.
module glpf_back import glpf_pkg::*; #(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          queue_empty,
	output logic                          pop,
	input  logic signed [SAMPLE_BITS-1:0] item_sample,
	input  logic [$clog2(MAX_ROWS)-1:0]   item_row,
	input  logic [$clog2(MAX_COLS)-1:0]   item_col,
	input  glpf_place_t                   item_place,
	output logic                          peak_valid,
	input  logic                          peak_stall,
	output logic [PEAK_ROW_W-1:0]         peak_row,
	output logic [PEAK_COL_W-1:0]         peak_col,
	output logic                          is_peak,
	output logic                          last
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CALC  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;
	localparam logic [1:0] ST_MARK  = 2'd3;

	logic [1:0] state_q;

	logic signed [SAMPLE_BITS-1:0] s_q;
	logic signed [SAMPLE_BITS-1:0] left_q;
	logic [RW-1:0]                 r_q;
	logic [CW-1:0]                 c_q;
	logic [CW-1:0]                 k_q;
	glpf_place_t                   place_q;

	logic signed [SAMPLE_BITS-1:0] near_mem [MAX_COLS];
	logic signed [SAMPLE_BITS-1:0] far_mem [MAX_COLS];
	logic [MAX_COLS-1:0]           near_vld_q;
	logic [MAX_COLS-1:0]           far_vld_q;
	logic [MAX_COLS-1:0]           flags_q;
	logic [MAX_COLS-1:0]           flags_upd;

	logic signed [SAMPLE_BITS-1:0] near_here_rd_q;
	logic signed [SAMPLE_BITS-1:0] near_right_rd_q;
	logic signed [SAMPLE_BITS-1:0] far_here_rd_q;
	logic signed [SAMPLE_BITS-1:0] far_left_rd_q;
	logic                          near_here_v_q;
	logic                          near_right_v_q;
	logic                          far_here_v_q;
	logic                          far_left_v_q;

	logic signed [SAMPLE_BITS-1:0] near_here;
	logic signed [SAMPLE_BITS-1:0] near_right;
	logic signed [SAMPLE_BITS-1:0] far_here;
	logic signed [SAMPLE_BITS-1:0] far_left;

	logic [CW-1:0] addr_right;
	logic [CW-1:0] addr_left;
	logic [CW-1:0] c_prev;

	logic out_valid_q;
	logic out_free;
	logic calc_go;
	logic flush_hit;
	logic flush_go;
	logic mark_go;
	logic frame_end;
	logic upper_ok;
	logic bottom_flag;
	logic load_out;

	assign pop = (state_q == ST_IDLE) && !queue_empty;

	// Neighbor addresses are clamped; the clamped reads are never used.
	assign addr_right = (item_col == CW'(MAX_COLS - 1)) ? item_col : item_col + 1'b1;
	assign addr_left  = (item_col == '0) ? item_col : item_col - 1'b1;
	assign c_prev     = c_q - 1'b1;

	always_ff @(posedge clk) begin
		if (pop) begin
			near_here_rd_q  <= near_mem[item_col];
			near_right_rd_q <= near_mem[addr_right];
			far_here_rd_q   <= far_mem[item_col];
			far_left_rd_q   <= far_mem[addr_left];
			near_here_v_q   <= near_vld_q[item_col];
			near_right_v_q  <= near_vld_q[addr_right];
			far_here_v_q    <= far_vld_q[item_col];
			far_left_v_q    <= far_vld_q[addr_left];
			s_q             <= item_sample;
			r_q             <= item_row;
			c_q             <= item_col;
			place_q         <= item_place;
		end
		if (calc_go) begin
			near_mem[c_q] <= s_q;
			far_mem[c_q]  <= near_here;
		end
	end

	// Entries never written since reset read as zero.
	assign near_here  = near_here_v_q  ? near_here_rd_q  : '0;
	assign near_right = near_right_v_q ? near_right_rd_q : '0;
	assign far_here   = far_here_v_q   ? far_here_rd_q   : '0;
	assign far_left   = far_left_v_q   ? far_left_rd_q   : '0;

	// The cell above the current sample is decided now: the far store holds
	// its upper neighbor, and at the left column it already holds the row above.
	assign upper_ok = (r_q != '0) && (near_here >= s_q)
		&& !((r_q > RW'(1)) && (near_here < far_here))
		&& !((c_q != '0) && (near_here < far_left))
		&& !(!place_q.last_col && (near_here < near_right));

	assign bottom_flag = !((r_q != '0) && (s_q < near_here))
		&& !((c_q != '0) && (s_q < left_q));

	// A larger sample removes the left neighbor's flag before this cell's flag is set.
	always_comb begin
		flags_upd = flags_q;
		if ((c_q != '0) && (left_q < s_q)) begin
			flags_upd[c_prev] = 1'b0;
		end
		flags_upd[c_q] = bottom_flag;
	end

	assign frame_end = place_q.last_row && place_q.last_col;
	assign out_free  = !out_valid_q || !peak_stall;
	assign calc_go   = (state_q == ST_CALC) && out_free;
	assign flush_hit = flags_q[k_q];
	assign flush_go  = (state_q == ST_FLUSH) && (!flush_hit || out_free);
	assign mark_go   = (state_q == ST_MARK) && out_free;
	assign load_out  = (calc_go && upper_ok) || (flush_go && flush_hit) || mark_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			left_q     <= '0;
			k_q        <= '0;
			near_vld_q <= '0;
			far_vld_q  <= '0;
			flags_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_go) begin
						near_vld_q[c_q] <= 1'b1;
						far_vld_q[c_q]  <= near_here_v_q;
						left_q          <= s_q;
						if (place_q.last_row) begin
							flags_q <= flags_upd;
						end
						k_q     <= '0;
						state_q <= frame_end ? ST_FLUSH : ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						if (k_q == c_q) begin
							state_q <= ST_MARK;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_MARK: begin
					if (mark_go) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!peak_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_CALC) begin
				peak_row <= PEAK_ROW_W'(r_q - 1'b1);
				peak_col <= PEAK_COL_W'(c_q);
				is_peak  <= 1'b1;
				last     <= !frame_end;
			end else if (state_q == ST_FLUSH) begin
				peak_row <= PEAK_ROW_W'(r_q);
				peak_col <= PEAK_COL_W'(k_q);
				is_peak  <= 1'b1;
				last     <= 1'b0;
			end else begin
				peak_row <= '0;
				peak_col <= '0;
				is_peak  <= 1'b0;
				last     <= 1'b1;
			end
		end
	end

	assign peak_valid = out_valid_q;

endmodule

// ----- hdl/grid_local_peak_finder_core.sv -----
// Top level of the 4-neighbor local maximum finder over a raster frame.
// The front end accepts one sample per cycle, while the queue is not full, into a
// two-item queue; the back end handles one item at a time: line store read, then
// decide and write back. Results are held in an output register. After the frame's
// final item the back end flushes the last-row flag of each column, then emits
// an end-of-frame marker. Asynchronous reset sets both counts to one and clears
// counters, line store valid bits, flags and the queue.
module grid_local_peak_finder_core import glpf_pkg::*; #(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          peak_valid,
	input  logic                          peak_stall,
	output logic [PEAK_ROW_W-1:0]         peak_row,
	output logic [PEAK_COL_W-1:0]         peak_col,
	output logic                          is_peak,
	output logic                          last
);

	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CW     = $clog2(MAX_COLS);
	localparam int DATA_W = SAMPLE_BITS + RW + CW + PLACE_W;

	logic                          push;
	logic signed [SAMPLE_BITS-1:0] push_sample;
	logic [RW-1:0]                 push_row;
	logic [CW-1:0]                 push_col;
	glpf_place_t                   push_place;
	logic                          queue_full;
	logic                          queue_empty;
	logic                          pop;
	logic [DATA_W-1:0]             pop_data;
	logic signed [SAMPLE_BITS-1:0] item_sample;
	logic [RW-1:0]                 item_row;
	logic [CW-1:0]                 item_col;
	glpf_place_t                   item_place;

	assign sample_stall = queue_full;

	glpf_front #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample_valid(sample_valid),
		.sample      (sample),
		.queue_full  (queue_full),
		.push        (push),
		.push_sample (push_sample),
		.push_row    (push_row),
		.push_col    (push_col),
		.push_place  (push_place)
	);

	glpf_queue #(
		.DATA_W(DATA_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_sample, push_row, push_col, push_place}),
		.full     (queue_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (queue_empty)
	);

	assign item_sample = pop_data[DATA_W-1 -: SAMPLE_BITS];
	assign item_row    = pop_data[RW+CW+PLACE_W-1 -: RW];
	assign item_col    = pop_data[CW+PLACE_W-1 -: CW];
	assign item_place  = pop_data[PLACE_W-1:0];

	glpf_back #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_empty(queue_empty),
		.pop        (pop),
		.item_sample(item_sample),
		.item_row   (item_row),
		.item_col   (item_col),
		.item_place (item_place),
		.peak_valid (peak_valid),
		.peak_stall (peak_stall),
		.peak_row   (peak_row),
		.peak_col   (peak_col),
		.is_peak    (is_peak),
		.last       (last)
	);

endmodule
